[design/twdp_pkg.sv]
// Shared types, widths and weight decoding for the ternary-weight dot product.
package twdp_pkg;

    localparam int unsigned MAX_ROW_GROUPS  = 2048;
    localparam int unsigned QUEUE_DEPTH_DEF = 4;

    localparam int unsigned CODE_W  = 8;
    localparam int unsigned ACT_W   = 16;
    localparam int unsigned SLOTS   = 4;
    // A group sum reaches +/-4 * 2^15, which needs 19 signed bits.
    localparam int unsigned GRP_W   = ACT_W + 3;
    localparam int unsigned SUM_W   = GRP_W + $clog2(MAX_ROW_GROUPS);
    localparam int unsigned RES_W   = 45;
    localparam int unsigned PROD_W  = SUM_W + ACT_W;

    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
    localparam logic signed [PROD_W-1:0] PROD_MAX =
        PROD_W'({1'b0, {(RES_W-1){1'b1}}});

    // Weight formats held in the format register.
    localparam logic FMT_DENSE  = 1'b0;
    localparam logic FMT_SPARSE = 1'b1;

    // Dense 2-bit weight codes; the other two codes mean zero.
    localparam logic [1:0] DENSE_NEG = 2'd0;
    localparam logic [1:0] DENSE_POS = 2'd2;

    typedef enum logic [1:0] {
        W_ZERO = 2'b00,
        W_POS  = 2'b01,
        W_NEG  = 2'b10
    } twdp_weight_t;

    typedef twdp_weight_t [SLOTS-1:0] twdp_weights_t;

    // One queue entry: the decoded group's contribution and its row markers.
    typedef struct packed {
        logic signed [GRP_W-1:0] grp_sum;
        logic signed [ACT_W-1:0] row_scale;
        logic                    row_end;
    } twdp_grp_t;

    function automatic twdp_weights_t decode_weights(logic [CODE_W-1:0] code, logic fmt);
        twdp_weights_t w;
        logic [1:0]    zs;
        logic [2:0]    signs;
        logic [1:0]    nxt;
        logic [1:0]    c;
        zs    = code[4:3];
        signs = code[2:0];
        nxt   = 2'd0;
        for (int s = 0; s < SLOTS; s++)
        begin
            if (fmt == FMT_DENSE)
            begin
                c = code[2*s +: 2];
                case (c)
                    DENSE_NEG: w[s] = W_NEG;
                    DENSE_POS: w[s] = W_POS;
                    default:   w[s] = W_ZERO;
                endcase
            end
            else if (2'(s) == zs)
            begin
                w[s] = W_ZERO;
            end
            else
            begin
                // Signs are consumed in slot order, skipping the zero slot.
                w[s] = signs[nxt] ? W_POS : W_NEG;
                nxt  = nxt + 2'd1;
            end
        end
        return w;
    endfunction

endpackage

[design/twdp_if.sv]
// Channel interfaces: group input, format register write and row result.
interface twdp_in_if;
    logic                                valid;
    logic                                ready;
    logic [twdp_pkg::CODE_W-1:0]         weight_code;
    logic signed [twdp_pkg::ACT_W-1:0]   act_slot0;
    logic signed [twdp_pkg::ACT_W-1:0]   act_slot1;
    logic signed [twdp_pkg::ACT_W-1:0]   act_slot2;
    logic signed [twdp_pkg::ACT_W-1:0]   act_slot3;
    logic signed [twdp_pkg::ACT_W-1:0]   row_scale;
    logic                                row_end;

    modport source (output valid, weight_code, act_slot0, act_slot1, act_slot2,
                    act_slot3, row_scale, row_end, input ready);
    modport sink   (input valid, weight_code, act_slot0, act_slot1, act_slot2,
                    act_slot3, row_scale, row_end, output ready);
endinterface

interface twdp_cfg_if;
    logic valid;
    logic ready;
    logic weight_format;

    modport source (output valid, weight_format, input ready);
    modport sink   (input valid, weight_format, output ready);
endinterface

interface twdp_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [twdp_pkg::RES_W-1:0]  row_result;

    modport source (output valid, row_result, input ready);
    modport sink   (input valid, row_result, output ready);
endinterface

[design/twdp_front.sv]
// Front end: accepts groups, decodes the weight code and forms the group sum.
module twdp_front (
    input  logic                clk,
    input  logic                rst_n,
    twdp_in_if.sink             grp,
    twdp_cfg_if.sink            cfg,
    input  logic                q_full,
    output logic                q_push,
    output twdp_pkg::twdp_grp_t q_wdata
);
    import twdp_pkg::*;

    logic                    fmt_reg;
    logic                    fmt_next;
    twdp_weights_t           wts;
    logic signed [ACT_W-1:0] act [SLOTS];
    logic signed [GRP_W-1:0] term [SLOTS];

    assign cfg.ready = 1'b1;
    assign fmt_next  = (cfg.valid) ? cfg.weight_format : fmt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fmt_reg <= FMT_DENSE;
        else
            fmt_reg <= fmt_next;
    end

    assign act[0] = grp.act_slot0;
    assign act[1] = grp.act_slot1;
    assign act[2] = grp.act_slot2;
    assign act[3] = grp.act_slot3;

    assign wts = decode_weights(grp.weight_code, fmt_reg);

    always_comb
    begin
        for (int s = 0; s < SLOTS; s++)
        begin
            case (wts[s])
                W_POS:   term[s] = GRP_W'(act[s]);
                W_NEG:   term[s] = -GRP_W'(act[s]);
                default: term[s] = '0;
            endcase
        end
    end

    assign grp.ready          = !q_full;
    assign q_push             = grp.valid && !q_full;
    assign q_wdata.grp_sum    = (term[0] + term[1]) + (term[2] + term[3]);
    assign q_wdata.row_scale  = grp.row_scale;
    assign q_wdata.row_end    = grp.row_end;

endmodule

[design/twdp_fifo.sv]
// Small flop-based queue between the front end and the accumulator.
module twdp_fifo #(
    parameter int unsigned DEPTH = twdp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  twdp_pkg::twdp_grp_t wdata,
    output logic                full,
    input  logic                pop,
    output logic                not_empty,
    output twdp_pkg::twdp_grp_t rdata
);
    import twdp_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    twdp_grp_t         entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign rdata     = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= wdata;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("queue count did not grow on a lone push");

    assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !push) |=> count_reg == $past(count_reg) - CNT_W'(1))
        else $error("queue count did not shrink on a lone pop");

endmodule

[design/twdp_back.sv]
// Back end: saturating row accumulator, scale multiplier and result register.
module twdp_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    input  twdp_pkg::twdp_grp_t q_rdata,
    output logic                q_pop,
    twdp_out_if.source          res
);
    import twdp_pkg::*;

    logic signed [SUM_W-1:0]  acc_reg;
    logic signed [SUM_W-1:0]  acc_next;
    logic signed [SUM_W:0]    sum_wide;
    logic signed [SUM_W-1:0]  sum_sat;

    logic                     mul_valid_reg;
    logic                     mul_valid_next;
    logic signed [SUM_W-1:0]  mul_sum_reg;
    logic signed [ACT_W-1:0]  mul_scale_reg;
    logic                     mul_free;
    logic                     mul_adv;
    logic                     mul_load;

    logic signed [PROD_W-1:0] prod;
    logic signed [RES_W-1:0]  prod_sat;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic signed [RES_W-1:0]  out_data_reg;
    logic                     out_load;

    assign sum_wide = (SUM_W+1)'(acc_reg) + (SUM_W+1)'(q_rdata.grp_sum);

    always_comb
    begin
        if (sum_wide > (SUM_W+1)'(SUM_MAX))
            sum_sat = SUM_MAX;
        else if (sum_wide < (SUM_W+1)'(SUM_MIN))
            sum_sat = SUM_MIN;
        else
            sum_sat = sum_wide[SUM_W-1:0];
    end

    assign out_load = !out_valid_reg || res.ready;
    assign mul_adv  = mul_valid_reg && out_load;
    assign mul_free = !mul_valid_reg || out_load;

    // A group that does not end a row never waits on the multiplier.
    assign q_pop    = q_valid && (!q_rdata.row_end || mul_free);
    assign mul_load = q_pop && q_rdata.row_end;

    always_comb
    begin
        acc_next = acc_reg;
        if (q_pop)
            acc_next = q_rdata.row_end ? '0 : sum_sat;
    end

    always_comb
    begin
        mul_valid_next = mul_valid_reg;
        if (mul_load)
            mul_valid_next = 1'b1;
        else if (mul_adv)
            mul_valid_next = 1'b0;
    end

    // Only the most negative sum times the most negative scale overflows.
    assign prod = PROD_W'(mul_sum_reg) * PROD_W'(mul_scale_reg);
    assign prod_sat = (prod > PROD_MAX) ? PROD_MAX[RES_W-1:0] : prod[RES_W-1:0];

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (mul_adv)
            out_valid_next = 1'b1;
        else if (res.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            mul_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg       <= acc_next;
            mul_valid_reg <= mul_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mul_load)
        begin
            mul_sum_reg   <= sum_sat;
            mul_scale_reg <= q_rdata.row_scale;
        end
        if (mul_adv)
            out_data_reg <= prod_sat;
    end

    assign res.valid      = out_valid_reg;
    assign res.row_result = out_data_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        mul_load |=> acc_reg == '0)
        else $error("row sum not cleared after the last group of a row");

    assert property (@(posedge clk) disable iff (!rst_n)
        (mul_valid_reg && !mul_adv) |=> mul_valid_reg && $stable(mul_sum_reg)
            && $stable(mul_scale_reg))
        else $error("pending row total was overwritten before reaching the output");

    assert property (@(posedge clk) disable iff (!rst_n)
        (q_valid && q_rdata.row_end && mul_valid_reg && !out_load) |-> !q_pop)
        else $error("row end popped while the multiplier stage was blocked");

endmodule

[design/ternary_weight_dot_product.sv]
// Top level of the ternary-weight dot product engine.
//
// Channels: grp carries one group per word (a packed weight code, four signed
// Q4.11 activations, the row scale and a row-end flag). res returns one Q22.22
// word per row, on the group marked row_end. cfg writes the one-bit weight
// format (dense 2-bit codes or 3:4 sparse) and is always ready; write it only
// while no row is in flight.
// Throughput is one group per cycle while the input queue is not full.
// A group is decoded and summed on entry into the input queue, added into
// the row sum from the queue head, and for a row end the row total and scale
// load the multiplier register; the 30x16 multiply sits alone between it
// and the output register, which drives res.valid.
// When res is stalled, ordinary groups keep accumulating and two finished
// rows are held in the multiplier and output registers; a third row end
// waits, and the input queue (QUEUE_DEPTH words) then fills before
// grp.ready drops. grp.ready depends only on the queue fill level.
// Reset clears the row sum, the queue and the output, and sets the dense
// weight format.
module ternary_weight_dot_product #(
    parameter int unsigned QUEUE_DEPTH = twdp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    twdp_in_if.sink     grp,
    twdp_cfg_if.sink    cfg,
    twdp_out_if.source  res
);
    import twdp_pkg::*;

    logic      q_full;
    logic      q_push;
    logic      q_pop;
    logic      q_valid;
    twdp_grp_t q_wdata;
    twdp_grp_t q_rdata;

    twdp_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .grp     (grp),
        .cfg     (cfg),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_wdata (q_wdata)
    );

    twdp_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .wdata     (q_wdata),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .rdata     (q_rdata)
    );

    twdp_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_rdata (q_rdata),
        .q_pop   (q_pop),
        .res     (res)
    );

endmodule

[dv/ternary_weight_dot_product_tb.sv]
// Self-checking testbench for the ternary-weight dot product engine.
`timescale 1ns / 1ps

module ternary_weight_dot_product_tb;

    import twdp_pkg::*;

    typedef enum logic [1:0] {
        STEP_GROUP,
        STEP_FORMAT,
        STEP_DRAIN
    } feed_kind_t;

    typedef struct packed {
        logic [CODE_W-1:0]            code;
        logic [SLOTS-1:0][ACT_W-1:0]  act;
        logic signed [ACT_W-1:0]      scale;
        logic                         row_end;
    } group_word_t;

    typedef struct {
        feed_kind_t   kind;
        group_word_t  word;
        logic         fmt;
        int unsigned  gap;
    } feed_step_t;

    localparam logic [ACT_W-1:0]  ACT_MOST_NEG = {1'b1, {(ACT_W-1){1'b0}}};
    localparam logic [ACT_W-1:0]  ACT_MOST_POS = {1'b0, {(ACT_W-1){1'b1}}};
    localparam logic [CODE_W-1:0] DENSE_ALL_NEG = 8'h00;
    localparam logic [CODE_W-1:0] DENSE_ALL_POS = 8'hAA;
    localparam int RAND_PHASES   = 6;
    localparam int PHASE_GROUPS  = 225;
    localparam int SETTLE_CYCLES = 16;
    localparam int TAIL_CYCLES   = 20;
    localparam int QUIET_LIMIT   = 2000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic        drv_grp_valid = 1'b0;
    group_word_t drv_word = '0;
    logic        drv_cfg_valid = 1'b0;
    logic        drv_fmt = 1'b0;
    logic        drv_res_ready = 1'b0;

    twdp_in_if  grp_if ();
    twdp_cfg_if cfg_if ();
    twdp_out_if res_if ();

    assign grp_if.valid       = drv_grp_valid;
    assign grp_if.weight_code = drv_word.code;
    assign grp_if.act_slot0   = drv_word.act[0];
    assign grp_if.act_slot1   = drv_word.act[1];
    assign grp_if.act_slot2   = drv_word.act[2];
    assign grp_if.act_slot3   = drv_word.act[3];
    assign grp_if.row_scale   = drv_word.scale;
    assign grp_if.row_end     = drv_word.row_end;
    assign cfg_if.valid         = drv_cfg_valid;
    assign cfg_if.weight_format = drv_fmt;
    assign res_if.ready = drv_res_ready;

    ternary_weight_dot_product u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .grp   (grp_if),
        .cfg   (cfg_if),
        .res   (res_if)
    );

    // Predictor state and the rows still waiting to come out.
    logic                    fmt_model = FMT_DENSE;
    logic signed [SUM_W-1:0] row_sum_model = '0;
    logic signed [RES_W-1:0] row_results_q [$];

    feed_step_t group_feed_q [$];
    int idle_left = 0;
    int settle_left = SETTLE_CYCLES;
    int stall_left = 0;
    int mismatches = 0;
    int quiet_cycles = 0;
    bit in_calm = 1'b0;
    bit out_calm = 1'b0;

    function automatic void fold_group(group_word_t w);
        twdp_weight_t wt [SLOTS];
        logic [1:0]   zero_slot;
        int unsigned  sign_idx;
        longint       acc;
        longint       total;
        longint       prod;
        zero_slot = w.code[4:3];
        sign_idx  = 0;
        acc       = 0;
        for (int s = 0; s < SLOTS; s++)
        begin
            if (fmt_model == FMT_DENSE)
            begin
                case (w.code[2*s +: 2])
                    DENSE_NEG: wt[s] = W_NEG;
                    DENSE_POS: wt[s] = W_POS;
                    default:   wt[s] = W_ZERO;
                endcase
            end
            else if (s == int'(zero_slot))
                wt[s] = W_ZERO;
            else
            begin
                wt[s] = w.code[sign_idx] ? W_POS : W_NEG;
                sign_idx++;
            end
            if (wt[s] == W_POS)
                acc += longint'($signed(w.act[s]));
            else if (wt[s] == W_NEG)
                acc -= longint'($signed(w.act[s]));
        end
        total = longint'(row_sum_model) + acc;
        if (total > longint'(SUM_MAX))
            total = longint'(SUM_MAX);
        if (total < longint'(SUM_MIN))
            total = longint'(SUM_MIN);
        row_sum_model = SUM_W'(total);
        if (w.row_end)
        begin
            // Only the most negative sum times the most negative scale overflows.
            prod = longint'(row_sum_model) * longint'(w.scale);
            if (prod > (longint'(1) <<< (RES_W - 1)) - 1)
                prod = (longint'(1) <<< (RES_W - 1)) - 1;
            row_results_q.push_back(RES_W'(prod));
            row_sum_model = '0;
        end
    endfunction

    task automatic push_group(logic [CODE_W-1:0] code, logic [ACT_W-1:0] a0,
                              logic [ACT_W-1:0] a1, logic [ACT_W-1:0] a2,
                              logic [ACT_W-1:0] a3, logic [ACT_W-1:0] scale,
                              logic last, int unsigned gap);
        feed_step_t st;
        st.kind         = STEP_GROUP;
        st.word.code    = code;
        st.word.act     = {a3, a2, a1, a0};
        st.word.scale   = scale;
        st.word.row_end = last;
        st.fmt          = FMT_DENSE;
        st.gap          = gap;
        group_feed_q.push_back(st);
    endtask

    task automatic push_control(feed_kind_t kind, logic fmt);
        feed_step_t st;
        st.kind = kind;
        st.word = '0;
        st.fmt  = fmt;
        st.gap  = $urandom_range(0, 13);
        group_feed_q.push_back(st);
    endtask

    function automatic logic [ACT_W-1:0] pick_act();
        case ($urandom_range(0, 7))
            0:       return ACT_MOST_NEG;
            1:       return ACT_MOST_POS;
            2:       return '0;
            3:       return ACT_W'(int'($urandom_range(0, 64)) - 32);
            default: return ACT_W'($urandom());
        endcase
    endfunction

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        int row_len;
        int sent;
        bit paused;

        // Dense codes: all -1, all +1, all zero, each code in its own slot.
        push_control(STEP_FORMAT, FMT_DENSE);
        push_group(DENSE_ALL_NEG, ACT_MOST_NEG, ACT_MOST_NEG, ACT_MOST_NEG, ACT_MOST_NEG,
                   ACT_MOST_NEG, 1'b1, 0);
        push_group(DENSE_ALL_POS, ACT_MOST_POS, ACT_MOST_POS, ACT_MOST_POS, ACT_MOST_POS,
                   ACT_MOST_POS, 1'b1, 3);
        push_group(8'hFF, pick_act(), pick_act(), pick_act(), pick_act(), ACT_MOST_POS,
                   1'b1, 0);
        push_group(8'h55, pick_act(), pick_act(), pick_act(), pick_act(), pick_act(),
                   1'b1, 1);
        push_group(8'hE4, 16'h1000, 16'h2000, 16'h3000, 16'h4000, 16'h0800, 1'b1, 0);
        push_group(8'h12, pick_act(), pick_act(), pick_act(), pick_act(), pick_act(),
                   1'b0, 0);
        push_group(8'h9C, pick_act(), pick_act(), pick_act(), pick_act(), pick_act(),
                   1'b0, 0);
        push_group(8'h61, pick_act(), pick_act(), pick_act(), pick_act(), ACT_MOST_NEG,
                   1'b1, 2);
        push_group(DENSE_ALL_POS, '0, '0, '0, '0, ACT_MOST_NEG, 1'b1, 0);

        // Sparse codes, every zero slot, upper code bits set and clear.
        push_control(STEP_FORMAT, FMT_SPARSE);
        push_group(8'h07, ACT_MOST_POS, ACT_MOST_POS, ACT_MOST_POS, ACT_MOST_POS,
                   ACT_MOST_POS, 1'b1, 0);
        push_group(8'h18, ACT_MOST_NEG, ACT_MOST_NEG, ACT_MOST_NEG, ACT_MOST_NEG,
                   ACT_MOST_NEG, 1'b1, 0);
        push_group(8'hE8, pick_act(), pick_act(), pick_act(), pick_act(), pick_act(),
                   1'b1, 4);
        push_group(8'hF7, pick_act(), pick_act(), pick_act(), pick_act(), pick_act(),
                   1'b1, 0);
        push_group(8'h1D, 16'h0100, 16'h0200, 16'h0400, 16'h0800, 16'h0800, 1'b1, 0);
        push_group(8'h0A, pick_act(), pick_act(), pick_act(), pick_act(), pick_act(),
                   1'b0, 0);
        push_group(8'h13, pick_act(), pick_act(), pick_act(), pick_act(), pick_act(),
                   1'b1, 0);

        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            push_control(STEP_FORMAT, (ph % 2 == 0) ? FMT_SPARSE : FMT_DENSE);
            sent   = 0;
            paused = 1'b0;
            while (sent < PHASE_GROUPS)
            begin
                row_len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40)
                                                      : $urandom_range(1, 8);
                if ($urandom_range(0, 7) == 0)
                    in_calm = !in_calm;
                for (int g = 0; g < row_len; g++)
                    push_group(CODE_W'($urandom_range(0, 255)), pick_act(), pick_act(),
                               pick_act(), pick_act(), pick_act(), g == row_len - 1,
                               in_calm ? 0 : $urandom_range(0, 13));
                sent += row_len;
                // Hold the sender until every pending row has come out.
                if (!paused && sent >= PHASE_GROUPS / 2)
                begin
                    push_control(STEP_DRAIN, FMT_DENSE);
                    paused = 1'b1;
                end
            end
        end
    end

    always @(posedge clk)
    begin : feed_driver
        feed_step_t head;
        logic grp_next;
        logic cfg_next;
        logic popped;
        if (!rst_n)
        begin
            drv_grp_valid <= 1'b0;
            drv_cfg_valid <= 1'b0;
        end
        else
        begin
            grp_next = drv_grp_valid;
            cfg_next = drv_cfg_valid;
            popped   = 1'b0;
            if (drv_grp_valid && grp_if.ready)
            begin
                fold_group(drv_word);
                grp_next = 1'b0;
            end
            if (drv_cfg_valid && cfg_if.ready)
            begin
                fmt_model = drv_fmt;
                cfg_next  = 1'b0;
            end
            if (!grp_next && !cfg_next && group_feed_q.size() != 0)
            begin
                head = group_feed_q[0];
                if (idle_left > 0)
                    idle_left--;
                else if (head.kind == STEP_GROUP)
                begin
                    drv_word    <= head.word;
                    grp_next    = 1'b1;
                    settle_left = SETTLE_CYCLES;
                    popped      = 1'b1;
                end
                // Format writes and pauses wait for an empty pipe.
                else if (row_results_q.size() != 0)
                    settle_left = SETTLE_CYCLES;
                else if (settle_left > 0)
                    settle_left--;
                else
                begin
                    if (head.kind == STEP_FORMAT)
                    begin
                        drv_fmt  <= head.fmt;
                        cfg_next = 1'b1;
                    end
                    popped = 1'b1;
                end
            end
            if (popped)
            begin
                group_feed_q.delete(0);
                if (group_feed_q.size() != 0)
                    idle_left = group_feed_q[0].gap;
            end
            drv_grp_valid <= grp_next;
            drv_cfg_valid <= cfg_next;
        end
    end

    always @(posedge clk)
    begin : result_monitor
        logic signed [RES_W-1:0] want;
        if (!rst_n)
            drv_res_ready <= 1'b0;
        else
        begin
            if (res_if.valid && res_if.ready)
            begin
                if (row_results_q.size() == 0)
                begin
                    $error("row_result: expected no word, got %0d", res_if.row_result);
                    mismatches++;
                end
                else
                begin
                    want = row_results_q.pop_front();
                    if (res_if.row_result !== want)
                    begin
                        $error("row_result: expected %0d, got %0d", want, res_if.row_result);
                        mismatches++;
                    end
                end
                if ($urandom_range(0, 31) == 0)
                    out_calm = !out_calm;
                stall_left = out_calm ? 0 : $urandom_range(0, 13);
            end
            if (stall_left > 0)
            begin
                stall_left--;
                drv_res_ready <= 1'b0;
            end
            else
                drv_res_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if ((grp_if.valid && grp_if.ready) || (cfg_if.valid && cfg_if.ready) ||
            (res_if.valid && res_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        wait (rst_n);
        while (!(group_feed_q.size() == 0 && !drv_grp_valid && !drv_cfg_valid &&
                 row_results_q.size() == 0) && quiet_cycles < QUIET_LIMIT)
            @(posedge clk);
        if (quiet_cycles < QUIET_LIMIT)
            repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && quiet_cycles < QUIET_LIMIT)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
